// ===== design/fixed_point_alu_assert.svh =====
// assertion macros for the fixed-point alu
// clocked on clk_i, reset rst_ni; no other dependencies
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// property checked only out of reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked also during reset
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
// shared types, op codes and saturation helpers for the fixed-point alu
// no dependencies
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_GE     = 4'd6,
    OP_LE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_MIN    = 4'd10,
    OP_MAX    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TO_INT = 4'd14
  } op_e;

  // which datapath supplies the final result
  typedef enum logic [1:0] {
    SEL_SIMPLE,
    SEL_MUL,
    SEL_DIV
  } sel_e;

  typedef struct packed {
    logic        valid;
    sel_e        sel;
    logic [31:0] res;
    logic        flag;
    logic        err;
    logic        neg;
    logic        dz;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
  } front_t;

  typedef struct packed {
    logic        err;
    logic [31:0] res;
  } mulres_t;

  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg = 32'h8000_0000;

  // clamp a 33-bit signed sum to 32 bits, {err, res}
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic [32:0] r;
    begin
      if (s[32] != s[31]) begin
        r = {1'b1, (s[32] ? MinNeg : MaxPos)};
      end else begin
        r = {1'b0, s[31:0]};
      end
      return r;
    end
  endfunction

  // build a signed value from sign and magnitude, saturating, {err, res}
  function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    begin
      if (!neg) begin
        if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, MaxPos};
        else r = {1'b0, mag[31:0]};
      end else begin
        if (mag > 64'h0000_0000_8000_0000) r = {1'b1, MinNeg};
        else r = {1'b0, (~mag[31:0]) + 32'd1};
      end
      return r;
    end
  endfunction

endpackage

// ===== design/fixed_point_alu.sv =====
// Fixed-point alu for signed 32-bit numbers with FRAC_BITS fraction bits.
// Input channel: in_valid_i / in_ready_o with cmd_i, operand_a_i, operand_b_i.
// Output channel: out_valid_o / out_ready_i with result_o, flag_o, error_o.
// Every op code, including unused ones, gives exactly one result beat.
// The path from accept to out_valid_o is the same length for all operations,
// so results leave in the order items came in.
// Throughput: one beat per cycle while not stalled; the divider, which resolves
// one quotient bit per stage over 32 + FRAC_BITS stages, sets the depth.
// Multiply uses one 32x32 product stage and one rounding stage.
// The whole pipeline advances together; when the receiver holds out_ready_i
// low with a result waiting, every stage freezes and in_ready_o drops, so
// nothing is lost or repeated. Empty stages are filled while the result waits
// only once it is taken.
// Reset clears all valid bits; the pipe is empty and in_ready_o is high
// straight after reset.
// depends on fpa_pkg, fpa_front, fpa_mul, fpa_div, fixed_point_alu_assert.svh
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_o,
  output logic               flag_o,
  output logic               error_o
);
  import fpa_pkg::*;
  `include "fixed_point_alu_assert.svh"

  localparam int unsigned W       = 32 + FRAC_BITS;
  localparam int unsigned MUL_DLY = W - 2;

  logic          en;
  front_t        front;
  mulres_t       mul_res;
  mulres_t       dly_q [MUL_DLY];
  side_t         side;
  logic [W-1:0]  div_quo;
  logic [31:0]   div_rem, div_den;
  logic          up;
  logic [W:0]    qr;
  logic [32:0]   dv;
  logic          out_valid_q, flag_q, error_q;
  logic [31:0]   result_q;
  logic [31:0]   result_d;
  logic          error_d;

  // whole pipe moves when the output register is free or being taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .front_o     (front)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_a_i (front.mag_a),
    .mag_b_i (front.mag_b),
    .neg_i   (front.side.neg),
    .res_o   (mul_res)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .front_i (front),
    .side_o  (side),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .den_o   (div_den)
  );

  // line up the product with the end of the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= mul_res;
      for (int i = 1; i < MUL_DLY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // quotient rounding: up when twice the remainder reaches the divisor
  assign up = {div_rem, 1'b0} >= {1'b0, div_den};
  assign qr = {1'b0, div_quo} + (W+1)'(up);
  assign dv = from_mag(side.neg, 64'(qr));

  // result select
  always_comb begin
    case (side.sel)
      SEL_MUL: begin
        result_d = dly_q[MUL_DLY-1].res;
        error_d  = dly_q[MUL_DLY-1].err;
      end
      SEL_DIV: begin
        result_d = side.dz ? 32'd0 : dv[31:0];
        error_d  = side.dz ? 1'b1 : dv[32];
      end
      default: begin
        result_d = side.res;
        error_d  = side.err;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      flag_q   <= side.flag;
      error_q  <= error_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign flag_o      = flag_q;
  assign error_o     = error_q;

  // checks
  `FPA_ASSERT(a_flag_clean, out_valid_o && flag_o |-> !error_o && result_o == 32'sd0, "flag with result")
  `FPA_ASSERT(a_err_value, out_valid_o && error_o |-> result_o == 32'sh7FFF_FFFF || result_o == 32'sh8000_0000 || result_o == 32'sd0, "error without bound")
  `FPA_ASSERT(a_accept_front, in_valid_i && in_ready_o |=> front.side.valid, "accepted beat lost")
  `FPA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

// ===== design/fpa_front.sv =====
// input stage: decode, magnitudes and the simple operations
// depends on fpa_pkg
module fpa_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [3:0]          cmd_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output fpa_pkg::front_t     front_o
);
  import fpa_pkg::*;

  front_t      front_d, front_q;
  logic [32:0] a_x, b_x;
  logic [32:0] sr;
  logic [31:0] mag_a, mag_b;

  // sign-extended operands and magnitudes
  assign a_x   = {operand_a_i[31], operand_a_i};
  assign b_x   = {operand_b_i[31], operand_b_i};
  assign mag_a = operand_a_i[31] ? (~operand_a_i) + 32'd1 : operand_a_i;
  assign mag_b = operand_b_i[31] ? (~operand_b_i) + 32'd1 : operand_b_i;

  // simple operations
  always_comb begin
    sr = '0;
    front_d = '0;
    front_d.side.valid = in_valid_i;
    front_d.side.sel   = SEL_SIMPLE;
    front_d.side.neg   = operand_a_i[31] ^ operand_b_i[31];
    front_d.side.dz    = (operand_b_i == 32'sd0);
    front_d.mag_a      = mag_a;
    front_d.mag_b      = mag_b;
    case (op_e'(cmd_i))
      OP_ADD:    sr = sat33(a_x + b_x);
      OP_SUB:    sr = sat33(a_x - b_x);
      OP_MUL:    front_d.side.sel = SEL_MUL;
      OP_DIV:    front_d.side.sel = SEL_DIV;
      OP_GT:     front_d.side.flag = operand_a_i > operand_b_i;
      OP_LT:     front_d.side.flag = operand_a_i < operand_b_i;
      OP_GE:     front_d.side.flag = operand_a_i >= operand_b_i;
      OP_LE:     front_d.side.flag = operand_a_i <= operand_b_i;
      OP_EQ:     front_d.side.flag = operand_a_i == operand_b_i;
      OP_NE:     front_d.side.flag = operand_a_i != operand_b_i;
      OP_MIN:    sr = {1'b0, (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i};
      OP_MAX:    sr = {1'b0, (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i};
      OP_INC:    sr = sat33(a_x + 33'd1);
      OP_DEC:    sr = sat33(a_x - 33'd1);
      OP_TO_INT: sr = from_mag(operand_a_i[31], 64'(mag_a >> FRAC_BITS));
      default:   sr = '0;
    endcase
    front_d.side.err = sr[32];
    front_d.side.res = sr[31:0];
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== design/fpa_mul.sv =====
// two-stage multiplier: magnitude product, then rounding and saturation
// depends on fpa_pkg
module fpa_mul #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [31:0]      mag_a_i,
  input  logic [31:0]      mag_b_i,
  input  logic             neg_i,
  output fpa_pkg::mulres_t res_o
);
  import fpa_pkg::*;

  logic [63:0] prod_q;
  logic        neg_q;
  logic [63:0] rnd;
  mulres_t     res_d, res_q;

  // round half away from zero on the magnitude
  assign rnd   = (prod_q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign res_d = mulres_t'(from_mag(neg_q, rnd));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(mag_a_i) * 64'(mag_b_i);
      neg_q  <= neg_i;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/fpa_div.sv =====
// restoring divider, one quotient bit per pipeline stage
// depends on fpa_pkg; carries the side beat of every item alongside
module fpa_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  fpa_pkg::front_t         front_i,
  output fpa_pkg::side_t          side_o,
  output logic [32+FRAC_BITS-1:0] quo_o,
  output logic [31:0]             rem_o,
  output logic [31:0]             den_o
);
  import fpa_pkg::*;

  localparam int unsigned W = 32 + FRAC_BITS;

  side_t          side_q [W];
  logic [W-1:0]   num_q  [W];
  logic [W-1:0]   quo_q  [W];
  logic [31:0]    rem_q  [W];
  logic [31:0]    den_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    side_t        side_in;
    logic [W-1:0] num_in, quo_in;
    logic [31:0]  rem_in, den_in;
    logic [32:0]  rem_sh, rem_sub;
    logic         ge;

    if (k == 0) begin : g_first
      assign side_in = front_i.side;
      assign num_in  = {front_i.mag_a, {FRAC_BITS{1'b0}}};
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign den_in  = front_i.mag_b;
    end else begin : g_next
      assign side_in = side_q[k-1];
      assign num_in  = num_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // shift in the next dividend bit and try the subtraction
    assign rem_sh  = {rem_in, num_in[W-1]};
    assign ge      = rem_sh >= {1'b0, den_in};
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in << 1;
        quo_q[k] <= {quo_in[W-2:0], ge};
        rem_q[k] <= ge ? rem_sub[31:0] : rem_sh[31:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign side_o = side_q[W-1];
  assign quo_o  = quo_q[W-1];
  assign rem_o  = rem_q[W-1];
  assign den_o  = den_q[W-1];

endmodule
